// ===== design/tks_pkg.sv =====
// Package for the top-k ranked stats core: widths, entry and control types,
// configuration codes and the sort-key helpers.
// No dependencies.
package tks_pkg;

    localparam int ENTRIES       = 16;
    localparam int SECTIONS      = 10;
    localparam int DEFAULT_LIMIT = 10;
    localparam int CNT_W         = $clog2(ENTRIES + 1);
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int STAT_W        = 64;
    localparam int UID_W         = 16;
    localparam int SEC_W         = 4;
    localparam int RANK_W        = 32;
    localparam int IN_W          = 216;
    localparam int OUT_W         = 240;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_FIELD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZEROS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTALS_ONLY    = 3'd4;

    localparam logic [1:0] KEY_A = 2'd0;
    localparam logic [1:0] KEY_B = 2'd1;
    localparam logic [1:0] KEY_C = 2'd2;

    typedef struct packed {
        logic [UID_W-1:0]         user;
        logic signed [STAT_W-1:0] a;
        logic signed [STAT_W-1:0] b;
        logic signed [STAT_W-1:0] c;
    } t_entry;

    typedef struct packed {
        logic [1:0]       ksel;
        logic [SEC_W-1:0] section_select;
        logic             skip_zeros;
        logic             totals_only;
    } t_cfg;

    typedef struct packed {
        logic       ins;
        logic       shift;
        logic [1:0] ksel;
    } t_cell_ctl;

    function automatic logic signed [STAT_W-1:0] key_of(input t_entry e, input logic [1:0] k);
        logic signed [STAT_W-1:0] r;
        unique case (k)
            KEY_B:   r = e.b;
            KEY_C:   r = e.c;
            default: r = e.a;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tks_cell.sv =====
// One list cell of the top-k core: holds one ranked entry, compares it
// against the user being inserted and hands entries to its neighbors.
// Depends on tks_pkg.
module tks_cell (
    input  logic               i_clk,
    input  tks_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  tks_pkg::t_entry    i_new,
    input  tks_pkg::t_entry    i_prev,
    input  logic               i_prev_ahead,
    input  tks_pkg::t_entry    i_next,
    output tks_pkg::t_entry    o_ent,
    output logic               o_ahead
);
    import tks_pkg::*;

    t_entry                   r_ent;
    logic signed [STAT_W-1:0] w_own_key;
    logic signed [STAT_W-1:0] w_new_key;

    assign w_own_key = key_of(r_ent, i_ctl.ksel);
    assign w_new_key = key_of(i_new, i_ctl.ksel);
    assign o_ahead   = i_valid && ((w_own_key > w_new_key) ||
                       ((w_own_key == w_new_key) && (r_ent.user < i_new.user)));
    assign o_ent     = r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_ent <= i_next;
        end else if (i_ctl.ins && !o_ahead) begin
            r_ent <= i_prev_ahead ? i_new : i_prev;
        end
    end

endmodule

// ===== design/tks_judge.sv =====
// Per-user accumulation and judging stage of the top-k core: sums the
// selected section records, judges each finished user and keeps the totals.
// Depends on tks_pkg.
module tks_judge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tks_pkg::t_cfg                i_cfg,
    input  logic                         i_add,
    input  logic                         i_fin,
    input  logic                         i_last,
    input  logic [tks_pkg::SEC_W-1:0]    i_section,
    input  tks_pkg::t_entry              i_rec,
    input  logic                         i_clear,
    output logic                         o_ins_valid,
    output tks_pkg::t_entry              o_ins,
    output tks_pkg::t_entry              o_tot,
    output logic [tks_pkg::RANK_W-1:0]   o_matched
);
    import tks_pkg::*;

    t_entry              r_acc;
    t_entry              r_j;
    logic                r_j_valid;
    t_entry              r_tot;
    logic [RANK_W-1:0]   r_matched;
    logic                w_take;
    logic                w_match;
    t_entry              w_sum;

    assign w_take = (i_cfg.section_select >= SEC_W'(SECTIONS)) ?
                    (i_section < SEC_W'(SECTIONS)) : (i_section == i_cfg.section_select);

    always_comb begin
        w_sum      = r_acc;
        w_sum.user = i_rec.user;
        if (w_take) begin
            w_sum.a = r_acc.a + i_rec.a;
            w_sum.b = r_acc.b + i_rec.b;
            w_sum.c = r_acc.c + i_rec.c;
        end
    end

    assign w_match     = r_j_valid && !(i_cfg.skip_zeros && (key_of(r_j, i_cfg.ksel) == '0));
    assign o_ins_valid = w_match && !i_cfg.totals_only;
    assign o_ins       = r_j;
    assign o_tot       = r_tot;
    assign o_matched   = r_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_j_valid <= 1'b0;
            r_tot     <= '0;
            r_matched <= '0;
        end else begin
            r_j_valid <= 1'b0;
            if (i_fin) begin
                r_acc <= '0;
            end else if (i_add) begin
                if (i_last) begin
                    r_acc     <= '0;
                    r_j       <= w_sum;
                    r_j_valid <= 1'b1;
                end else begin
                    r_acc <= w_sum;
                end
            end
            if (i_clear) begin
                r_tot     <= '0;
                r_matched <= '0;
            end else if (w_match) begin
                r_tot.a   <= r_tot.a + r_j.a;
                r_tot.b   <= r_tot.b + r_j.b;
                r_tot.c   <= r_tot.c + r_j.c;
                r_matched <= r_matched + 1'b1;
            end
        end
    end

endmodule

// ===== design/top_k_ranked_stats_core.sv =====
// Top level of the top-k ranked stats core: configuration registers, the
// chain of list cells, the judge stage and the result emitter.
// Depends on tks_pkg, tks_cell and tks_judge.
// Add records: one transfer per cycle while in the run state; a finished user
// is registered in the judge stage, then enters the list through the cell
// chain compare. Finish: the finish transfer moves the core to the emit state,
// then one result per cycle while the sink takes them (entries plus totals); the
// input stalls until the totals item is loaded into the output register.
// Reset: configuration to defaults, counts and sums cleared; list contents
// are not cleared, no clearing pass.
module top_k_ranked_stats_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tks_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tks_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // user_id[15:0], section[19:16], stat_a[83:20], stat_b[147:84],
    // stat_c[211:148], zero pad[215:212]
    input  logic [tks_pkg::IN_W-1:0]          s_axis_tdata,
    input  logic                              s_axis_tlast,   // user_last
    input  logic                              s_axis_tuser,   // req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rank_or_count[31:0], out_user[47:32], out_a[111:48], out_b[175:112],
    // out_c[239:176]
    output logic [tks_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tlast,   // last
    output logic                              m_axis_tuser    // record_kind
);
    import tks_pkg::*;

    typedef enum logic {S_RUN, S_EMIT} t_state;

    t_state            r_state;
    logic [1:0]        r_order;
    logic [SEC_W-1:0]  r_sect;
    logic [CNT_W-1:0]  r_max;
    logic              r_skip;
    logic              r_tonly;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_rank;
    logic              r_m_valid;
    logic              r_m_last;
    logic              r_m_kind;
    logic [OUT_W-1:0]  r_m_data;

    t_cfg              w_cfg;
    t_cell_ctl         w_ctl;
    t_entry            w_rec;
    t_entry            w_ins;
    t_entry            w_tot;
    logic [RANK_W-1:0] w_matched;
    logic              w_ins_valid;
    logic              w_accept;
    logic              w_add;
    logic              w_fin;
    logic              w_out_free;
    logic              w_emit_ent;
    logic              w_emit_tot;
    logic              w_do_ins;
    logic [CNT_W-1:0]  w_lim;
    logic [CNT_W-1:0]  w_ec;
    logic [CNT_W-1:0]  w_lim_m1;
    t_entry            w_ent   [ENTRIES];
    logic              w_ahead [ENTRIES];

    assign w_rec.user = s_axis_tdata[15:0];
    assign w_rec.a    = s_axis_tdata[83:20];
    assign w_rec.b    = s_axis_tdata[147:84];
    assign w_rec.c    = s_axis_tdata[211:148];

    assign s_axis_tready = (r_state == S_RUN);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_add         = w_accept && !s_axis_tuser;
    assign w_fin         = w_accept && s_axis_tuser;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_emit_ent    = (r_state == S_EMIT) && w_out_free && (r_count != '0);
    assign w_emit_tot    = (r_state == S_EMIT) && w_out_free && (r_count == '0);

    always_comb begin
        if (r_max == '0) begin
            w_lim = CNT_W'(DEFAULT_LIMIT);
        end else if (r_max > CNT_W'(ENTRIES)) begin
            w_lim = CNT_W'(ENTRIES);
        end else begin
            w_lim = r_max;
        end
    end

    assign w_ec     = (r_count > w_lim) ? w_lim : r_count;
    assign w_lim_m1 = w_lim - 1'b1;
    assign w_do_ins = w_ins_valid && !w_ahead[w_lim_m1[IDX_W-1:0]];

    always_comb begin
        n_count = r_count;
        if (w_ins_valid) begin
            n_count = w_ec;
            if (w_do_ins && (w_ec < w_lim)) begin
                n_count = w_ec + 1'b1;
            end
        end
    end

    assign w_cfg.ksel           = (r_order > KEY_C) ? KEY_A : r_order;
    assign w_cfg.section_select = r_sect;
    assign w_cfg.skip_zeros     = r_skip;
    assign w_cfg.totals_only    = r_tonly;

    assign w_ctl.ins   = w_do_ins;
    assign w_ctl.shift = w_emit_ent;
    assign w_ctl.ksel  = w_cfg.ksel;

    tks_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_add       (w_add),
        .i_fin       (w_fin),
        .i_last      (s_axis_tlast),
        .i_section   (s_axis_tdata[19:16]),
        .i_rec       (w_rec),
        .i_clear     (w_emit_tot),
        .o_ins_valid (w_ins_valid),
        .o_ins       (w_ins),
        .o_tot       (w_tot),
        .o_matched   (w_matched)
    );

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_ahead;
        if (i == 0) begin : g_first
            assign w_prev       = w_ins;
            assign w_prev_ahead = 1'b1;
        end else begin : g_mid
            assign w_prev       = w_ent[i-1];
            assign w_prev_ahead = w_ahead[i-1];
        end
        if (i == ENTRIES - 1) begin : g_last
            assign w_next = w_ent[i];
        end else begin : g_inner
            assign w_next = w_ent[i+1];
        end
        tks_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (CNT_W'(i) < w_ec),
            .i_new        (w_ins),
            .i_prev       (w_prev),
            .i_prev_ahead (w_prev_ahead),
            .i_next       (w_next),
            .o_ent        (w_ent[i]),
            .o_ahead      (w_ahead[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd1;
            r_sect  <= SEC_W'(10);
            r_max   <= CNT_W'(10);
            r_skip  <= 1'b1;
            r_tonly <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORDER_FIELD:    r_order <= i_cfg_data[1:0];
                CFG_SECTION_SELECT: r_sect  <= i_cfg_data[SEC_W-1:0];
                CFG_MAX_ENTRIES:    r_max   <= i_cfg_data[CNT_W-1:0];
                CFG_SKIP_ZEROS:     r_skip  <= i_cfg_data[0];
                CFG_TOTALS_ONLY:    r_tonly <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_count   <= '0;
            r_rank    <= '0;
            r_m_valid <= 1'b0;
            r_m_last  <= 1'b0;
            r_m_kind  <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    r_count <= n_count;
                    r_rank  <= '0;
                    if (w_fin) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit_ent) begin
                        r_m_valid <= 1'b1;
                        r_m_last  <= 1'b0;
                        r_m_kind  <= 1'b0;
                        r_m_data  <= {w_ent[0].c, w_ent[0].b, w_ent[0].a, w_ent[0].user,
                                      RANK_W'(r_rank + 1'b1)};
                        r_rank    <= r_rank + 1'b1;
                        r_count   <= r_count - 1'b1;
                    end else if (w_emit_tot) begin
                        r_m_valid <= 1'b1;
                        r_m_last  <= 1'b1;
                        r_m_kind  <= 1'b1;
                        r_m_data  <= {w_tot.c, w_tot.b, w_tot.a, UID_W'(0), w_matched};
                        r_state   <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_kind;

endmodule
